[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the region scanner, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MMRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MMRS_ASSERT(label, clk, rst_n, prop, msg)

`define MMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/mmrs_pkg.sv]
// ----------------------------------------------------------------------------
// mmrs_pkg
// shared widths, codes and types of the memory map region scanner
// ----------------------------------------------------------------------------
`default_nettype none

package mmrs_pkg;

  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned START_W   = 52;
  localparam int unsigned PAGES_W   = 40;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 8'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW   = 2'd0,
    REG_WINDOW_HIGH  = 2'd1,
    REG_REQUEST_SIZE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] window_low;
    logic [DATA_W-1:0] window_high;
    logic [DATA_W-1:0] request_size;
  } cfg_t;

  typedef struct packed {
    logic conv;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] total_bytes;
    logic [DATA_W-1:0] usable_bytes;
    logic [DATA_W-1:0] top_address;
    logic              biggest_valid;
    logic [DATA_W-1:0] biggest_base;
    logic [DATA_W-1:0] biggest_length;
    logic              fit_valid;
    logic [DATA_W-1:0] fit_base;
    logic [DATA_W-1:0] fit_length;
    logic              final_result;
  } result_t;

endpackage

`default_nettype wire

[src/mmrs_in_if.sv]
// ----------------------------------------------------------------------------
// mmrs_in_if
// descriptor request channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mmrs_in_if;
  import mmrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  region_type;
  logic [START_W-1:0] region_start;
  logic [PAGES_W-1:0] region_pages;
  logic               last_entry;

  modport source (
    output valid, region_type, region_start, region_pages, last_entry,
    input  ready
  );

  modport sink (
    input  valid, region_type, region_start, region_pages, last_entry,
    output ready
  );

endinterface

`default_nettype wire

[src/mmrs_out_if.sv]
// ----------------------------------------------------------------------------
// mmrs_out_if
// result request channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mmrs_out_if;
  import mmrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] total_bytes;
  logic [DATA_W-1:0] usable_bytes;
  logic [DATA_W-1:0] top_address;
  logic              biggest_valid;
  logic [DATA_W-1:0] biggest_base;
  logic [DATA_W-1:0] biggest_length;
  logic              fit_valid;
  logic [DATA_W-1:0] fit_base;
  logic [DATA_W-1:0] fit_length;
  logic              final_result;

  modport source (
    output valid, total_bytes, usable_bytes, top_address, biggest_valid,
           biggest_base, biggest_length, fit_valid, fit_base, fit_length,
           final_result,
    input  ready
  );

  modport sink (
    input  valid, total_bytes, usable_bytes, top_address, biggest_valid,
           biggest_base, biggest_length, fit_valid, fit_base, fit_length,
           final_result,
    output ready
  );

endinterface

`default_nettype wire

[src/mmrs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mmrs_cfg_regs
// allocation window and request size registers
// ----------------------------------------------------------------------------
`default_nettype none

module mmrs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mmrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmrs_pkg::DATA_W-1:0]       cfg_data,
  output mmrs_pkg::cfg_t                    cfg
);
  import mmrs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:   cfg_nxt.window_low   = cfg_data;
        REG_WINDOW_HIGH:  cfg_nxt.window_high  = cfg_data;
        REG_REQUEST_SIZE: cfg_nxt.request_size = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_low   <= '0;
      cfg_r.window_high  <= '1;
      cfg_r.request_size <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/mmrs_in_stage.sv]
// ----------------------------------------------------------------------------
// mmrs_in_stage
// descriptor input register, forms region length and end address
// ----------------------------------------------------------------------------
`default_nettype none

module mmrs_in_stage #(
  parameter int unsigned PAGE_SHIFT = mmrs_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned LEN_W      = mmrs_pkg::PAGES_W + PAGE_SHIFT,
  parameter int unsigned END_W      =
    ((LEN_W > mmrs_pkg::START_W) ? LEN_W : mmrs_pkg::START_W) + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mmrs_in_if.sink                        in_if,
  output logic                           stg_valid,
  input  logic                           stg_ready,
  output logic [mmrs_pkg::START_W-1:0]   stg_start,
  output logic [LEN_W-1:0]               stg_len,
  output logic [END_W-1:0]               stg_end,
  output mmrs_pkg::item_ctl_t            stg_ctl
);
  import mmrs_pkg::*;

  logic               vld_r;
  logic               vld_nxt;
  logic               accept;
  logic [LEN_W-1:0]   len_nxt;
  logic [END_W-1:0]   end_nxt;
  item_ctl_t          ctl_nxt;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;
  logic [END_W-1:0]   end_r;
  item_ctl_t          ctl_r;

  assign in_if.ready = !vld_r || stg_ready;
  assign accept      = in_if.valid && in_if.ready;

  assign len_nxt      = {in_if.region_pages, {PAGE_SHIFT{1'b0}}};
  assign end_nxt      = END_W'(in_if.region_start) + END_W'(len_nxt);
  assign ctl_nxt.conv = (in_if.region_type == TYPE_CONVENTIONAL);
  assign ctl_nxt.last = in_if.last_entry;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (stg_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= in_if.region_start;
      len_r   <= len_nxt;
      end_r   <= end_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  assign stg_valid = vld_r;
  assign stg_start = start_r;
  assign stg_len   = len_r;
  assign stg_end   = end_r;
  assign stg_ctl   = ctl_r;

endmodule

`default_nettype wire

[src/mmrs_accum.sv]
// ----------------------------------------------------------------------------
// mmrs_accum
// running totals, largest region and best window fit, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mmrs_accum #(
  parameter int unsigned PAGE_SHIFT = mmrs_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned LEN_W      = mmrs_pkg::PAGES_W + PAGE_SHIFT,
  parameter int unsigned END_W      =
    ((LEN_W > mmrs_pkg::START_W) ? LEN_W : mmrs_pkg::START_W) + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmrs_pkg::cfg_t                 cfg,
  input  logic                           stg_valid,
  output logic                           stg_ready,
  input  logic [mmrs_pkg::START_W-1:0]   stg_start,
  input  logic [LEN_W-1:0]               stg_len,
  input  logic [END_W-1:0]               stg_end,
  input  mmrs_pkg::item_ctl_t            stg_ctl,
  mmrs_out_if.source                     out_if
);
  import mmrs_pkg::*;

  logic               advance;
  logic               out_vld_r;
  logic               out_vld_nxt;
  result_t            res_r;
  result_t            res_nxt;

  logic [DATA_W-1:0]  sum_all_r;
  logic [DATA_W-1:0]  sum_use_r;
  logic [END_W-1:0]   max_end_r;
  logic               big_seen_r;
  logic [START_W-1:0] big_start_r;
  logic [LEN_W-1:0]   big_size_r;
  logic               best_seen_r;
  logic [DATA_W-1:0]  best_start_r;
  logic [END_W-1:0]   best_size_r;

  logic [DATA_W-1:0]  sum_all_nxt;
  logic [DATA_W-1:0]  sum_use_nxt;
  logic [END_W-1:0]   max_end_nxt;
  logic               big_seen_nxt;
  logic [START_W-1:0] big_start_nxt;
  logic [LEN_W-1:0]   big_size_nxt;
  logic               best_seen_nxt;
  logic [DATA_W-1:0]  best_start_nxt;
  logic [END_W-1:0]   best_size_nxt;

  logic [DATA_W-1:0]  len64;
  logic [DATA_W-1:0]  start64;
  logic [DATA_W-1:0]  end64;
  logic [DATA_W:0]    sum_all_ext;
  logic [DATA_W:0]    sum_use_ext;
  logic [DATA_W-1:0]  sum_all_sat;
  logic [DATA_W-1:0]  sum_use_sat;
  logic               win_ok;
  logic [DATA_W-1:0]  clip_start;
  logic [DATA_W-1:0]  clip_end;
  logic [DATA_W-1:0]  clip_len;
  logic               fit_ok;

  logic               sum_usable_le_total;
  logic               big_flag_ok;
  logic               best_flag_ok;
  logic               acc_is_clear;

  assign stg_ready = !out_vld_r || out_if.ready;
  assign advance   = stg_valid && stg_ready;

  assign len64   = DATA_W'(stg_len);
  assign start64 = DATA_W'(stg_start);
  assign end64   = DATA_W'(stg_end);

  // saturating sums
  assign sum_all_ext = {1'b0, sum_all_r} + {1'b0, len64};
  assign sum_use_ext = {1'b0, sum_use_r} + {1'b0, len64};
  assign sum_all_sat = sum_all_ext[DATA_W] ? '1 : sum_all_ext[DATA_W-1:0];
  assign sum_use_sat = sum_use_ext[DATA_W] ? '1 : sum_use_ext[DATA_W-1:0];

  // clip to allocation window
  assign win_ok     = (cfg.window_low < cfg.window_high) && (end64 > cfg.window_low) &&
                      (start64 < cfg.window_high);
  assign clip_start = (start64 > cfg.window_low) ? start64 : cfg.window_low;
  assign clip_end   = (end64 < cfg.window_high) ? end64 : cfg.window_high;
  assign clip_len   = clip_end - clip_start;
  assign fit_ok     = win_ok && (clip_len >= cfg.request_size) &&
                      (clip_len > DATA_W'(best_size_r));

  always_comb begin
    sum_all_nxt    = sum_all_sat;
    sum_use_nxt    = sum_use_r;
    max_end_nxt    = max_end_r;
    big_seen_nxt   = big_seen_r;
    big_start_nxt  = big_start_r;
    big_size_nxt   = big_size_r;
    best_seen_nxt  = best_seen_r;
    best_start_nxt = best_start_r;
    best_size_nxt  = best_size_r;
    if (stg_end > max_end_r) begin
      max_end_nxt = stg_end;
    end
    if (stg_ctl.conv) begin
      sum_use_nxt = sum_use_sat;
      if (stg_len > big_size_r) begin
        big_seen_nxt  = 1'b1;
        big_start_nxt = stg_start;
        big_size_nxt  = stg_len;
      end
      if (fit_ok) begin
        best_seen_nxt  = 1'b1;
        best_start_nxt = clip_start;
        best_size_nxt  = clip_len[END_W-1:0];
      end
    end
  end

  always_comb begin
    res_nxt.total_bytes    = sum_all_nxt;
    res_nxt.usable_bytes   = sum_use_nxt;
    res_nxt.top_address    = DATA_W'(max_end_nxt);
    res_nxt.biggest_valid  = big_seen_nxt;
    res_nxt.biggest_base   = DATA_W'(big_start_nxt);
    res_nxt.biggest_length = DATA_W'(big_size_nxt);
    res_nxt.fit_valid      = best_seen_nxt;
    res_nxt.fit_base       = best_start_nxt;
    res_nxt.fit_length     = DATA_W'(best_size_nxt);
    res_nxt.final_result   = stg_ctl.last;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // accumulators, cleared after the closing descriptor
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && stg_ctl.last)) begin
      sum_all_r    <= '0;
      sum_use_r    <= '0;
      max_end_r    <= '0;
      big_seen_r   <= 1'b0;
      big_start_r  <= '0;
      big_size_r   <= '0;
      best_seen_r  <= 1'b0;
      best_start_r <= '0;
      best_size_r  <= '0;
    end else if (advance) begin
      sum_all_r    <= sum_all_nxt;
      sum_use_r    <= sum_use_nxt;
      max_end_r    <= max_end_nxt;
      big_seen_r   <= big_seen_nxt;
      big_start_r  <= big_start_nxt;
      big_size_r   <= big_size_nxt;
      best_seen_r  <= best_seen_nxt;
      best_start_r <= best_start_nxt;
      best_size_r  <= best_size_nxt;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.total_bytes    = res_r.total_bytes;
  assign out_if.usable_bytes   = res_r.usable_bytes;
  assign out_if.top_address    = res_r.top_address;
  assign out_if.biggest_valid  = res_r.biggest_valid;
  assign out_if.biggest_base   = res_r.biggest_base;
  assign out_if.biggest_length = res_r.biggest_length;
  assign out_if.fit_valid      = res_r.fit_valid;
  assign out_if.fit_base       = res_r.fit_base;
  assign out_if.fit_length     = res_r.fit_length;
  assign out_if.final_result   = res_r.final_result;

  assign sum_usable_le_total = (sum_use_r <= sum_all_r);
  assign big_flag_ok         = (big_seen_r == (big_size_r != '0));
  assign best_flag_ok        = (best_seen_r == (best_size_r != '0));
  assign acc_is_clear        = (sum_all_r == '0) && (max_end_r == '0) &&
                               !big_seen_r && !best_seen_r;

  `MMRS_ASSERT(a_usable_le_total, clk, rst_n, sum_usable_le_total, "usable above total")
  `MMRS_ASSERT(a_big_seen_size, clk, rst_n, big_flag_ok, "largest region flag mismatch")
  `MMRS_ASSERT(a_best_seen_size, clk, rst_n, best_flag_ok, "fit flag mismatch")
  `MMRS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && stg_ctl.last, acc_is_clear, "not cleared")

endmodule

`default_nettype wire

[src/memory_map_region_scanner_unit.sv]
// path: an accepted descriptor passes the input register, then the result register
// throughput: one descriptor per cycle when not stalled, set by the single accumulator stage
// input and result registers decouple the channels, a stalled result still takes one more item
// reset: synchronous active-low rst_n clears accumulators and restores window and size defaults
// ----------------------------------------------------------------------------
// memory_map_region_scanner_unit
// scans memory map descriptors and reports running totals and region picks
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_region_scanner_unit #(
  parameter int unsigned PAGE_SHIFT = mmrs_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mmrs_in_if.sink                        in_if,
  mmrs_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [mmrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmrs_pkg::DATA_W-1:0]    cfg_data
);
  import mmrs_pkg::*;

  localparam int unsigned LEN_W = PAGES_W + PAGE_SHIFT;
  localparam int unsigned END_W = ((LEN_W > START_W) ? LEN_W : START_W) + 1;

  cfg_t               cfg;
  logic               stg_valid;
  logic               stg_ready;
  logic [START_W-1:0] stg_start;
  logic [LEN_W-1:0]   stg_len;
  logic [END_W-1:0]   stg_end;
  item_ctl_t          stg_ctl;

  mmrs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mmrs_in_stage #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .LEN_W      (LEN_W),
    .END_W      (END_W)
  ) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_start (stg_start),
    .stg_len   (stg_len),
    .stg_end   (stg_end),
    .stg_ctl   (stg_ctl)
  );

  mmrs_accum #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .LEN_W      (LEN_W),
    .END_W      (END_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_start (stg_start),
    .stg_len   (stg_len),
    .stg_end   (stg_end),
    .stg_ctl   (stg_ctl),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire
